// ----- hw/rtl/sig_pkg.sv -----
// ----------------------------------------------------------------------------
// sig_pkg: shared types and constants for the sector interleave ID generator
// Register indexes, reset values, widths and the step unit's request and
// response words.
// ----------------------------------------------------------------------------
package sig_pkg;

    // Table size: the slot field names at most 32 slots
    localparam int MAX_SECTORS = 32;
    localparam int SLOT_CNT    = (MAX_SECTORS < 32) ? MAX_SECTORS : 32;
    localparam int SLOT_W      = 5;
    localparam int SEC_W       = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIZE       = 2'd2;

    localparam logic [SEC_W-1:0] RST_SECTORS_PER_TRACK = 6'd18;
    localparam logic [SEC_W-1:0] RST_INTERLEAVE        = 6'd1;
    localparam logic [15:0]      RST_SECTOR_SIZE       = 16'd512;

    // Size code remap: a code of 4 is reported as 3
    localparam logic [7:0] CODE_REMAP_FROM = 8'd4;
    localparam logic [7:0] CODE_REMAP_TO   = 8'd3;

    // Step unit request: advance a slot position with wrap at the track end
    typedef struct packed {
        logic [SLOT_W-1:0] pos;
        logic [SEC_W-1:0]  inc;
        logic [SEC_W-1:0]  n;
    } t_step_req;

    typedef struct packed {
        logic [SLOT_W-1:0] next;
        logic              wrap;
    } t_step_rsp;

endpackage

// ----- hw/rtl/sig_ram.sv -----
// ----------------------------------------------------------------------------
// sig_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents not reset.
// ----------------------------------------------------------------------------
module sig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/sig_step.sv -----
// ----------------------------------------------------------------------------
// sig_step: shared slot position stepper
// Adds a step to a slot position and wraps once past the end of the track.
// Used both for the interleave step and for the free-slot search.
// ----------------------------------------------------------------------------
module sig_step (
    input  sig_pkg::t_step_req i_req,
    output sig_pkg::t_step_rsp o_rsp
);
    import sig_pkg::*;

    logic [SEC_W:0] sum;
    logic [SEC_W:0] diff;

    // position < n and step < n, so one subtract brings it back in range
    assign sum  = {2'b00, i_req.pos} + {1'b0, i_req.inc};
    assign diff = sum - {1'b0, i_req.n};

    always_comb begin
        o_rsp.wrap = (sum >= {1'b0, i_req.n});
        o_rsp.next = o_rsp.wrap ? diff[SLOT_W-1:0] : sum[SLOT_W-1:0];
    end

endmodule

// ----- hw/rtl/sector_interleave_id_generator.sv -----
// ----------------------------------------------------------------------------
// A bad interleave puts its single error word out in the cycle after accept.
// Otherwise the table build places each sector in turn, searching for a free slot
// after each wrap, then each slot word passes through RAM read, load and hand-off.
// One track at a time: the input stalls until the last word is taken.
// Reset (synchronous, active low) restores register defaults and goes idle.
// ----------------------------------------------------------------------------
// sector_interleave_id_generator: floppy track ID field generator
// Places sectors 1..N every interleave slots in a slot table, skipping
// filled slots after a wrap, then emits one ID word per slot in slot order.
// ----------------------------------------------------------------------------
module sector_interleave_id_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [sig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sig_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    // track request
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_cylinder,
    input  logic [7:0]                       i_head,
    // ID words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sig_pkg::SLOT_W-1:0]       o_slot,
    output logic [7:0]                       o_id_cylinder,
    output logic [7:0]                       o_id_head,
    output logic [sig_pkg::SEC_W-1:0]        o_id_sector,
    output logic [7:0]                       o_size_code,
    output logic                             o_error,
    output logic                             o_last
);
    import sig_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_SEARCH,
        ST_RD,
        ST_LD,
        ST_OUT
    } t_state;

    // configuration registers
    logic [SEC_W-1:0] r_spt;
    logic [SEC_W-1:0] r_il;
    logic [15:0]      r_size;

    // sequencer state
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SEC_W-1:0]    r_sec, n_sec;
    logic [SLOT_W-1:0]   r_k, n_k;
    logic [SLOT_CNT-1:0] r_occ, n_occ;
    logic [7:0]          r_cyl, n_cyl;
    logic [7:0]          r_hd, n_hd;

    // output word
    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [7:0]          r_id_cyl, n_id_cyl;
    logic [7:0]          r_id_hd, n_id_hd;
    logic [SEC_W-1:0]    r_id_sec, n_id_sec;
    logic [7:0]          r_code, n_code;
    logic                r_err, n_err;
    logic                r_last, n_last;

    logic [SEC_W-1:0]    n_eff;
    logic [SEC_W-1:0]    il_eff;
    logic [7:0]          code;
    logic                bad_il;
    logic                in_acc;
    logic                k_last;
    logic                ram_wr_en;
    logic [SEC_W-1:0]    ram_rd_data;
    t_step_req           step_req;
    t_step_rsp           step_rsp;

    // effective track geometry and size code
    always_comb begin
        n_eff  = (r_spt > SEC_W'(SLOT_CNT)) ? SEC_W'(SLOT_CNT) : r_spt;
        il_eff = (r_il == '0) ? SEC_W'(1) : r_il;
        bad_il = (il_eff >= n_eff);
        code   = r_size[15:8];
        if (code == CODE_REMAP_FROM) begin
            code = CODE_REMAP_TO;
        end
    end

    assign in_acc     = i_in_valid && !o_in_stall;
    assign k_last     = (({1'b0, r_k} + SEC_W'(1)) == n_eff);
    assign ram_wr_en  = (r_state == ST_PLACE);

    // shared stepper: interleave step when placing, +1 when searching
    always_comb begin
        step_req.pos = r_pos;
        step_req.inc = (r_state == ST_SEARCH) ? SEC_W'(1) : il_eff;
        step_req.n   = n_eff;
    end

    sig_step u_step (
        .i_req (step_req),
        .o_rsp (step_rsp)
    );

    // slot table: sector number per slot, r_occ marks written slots
    sig_ram #(
        .WIDTH (SEC_W),
        .DEPTH (SLOT_CNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sec),
        .i_rd_addr (r_k),
        .o_rd_data (ram_rd_data)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_sec       = r_sec;
        n_k         = r_k;
        n_occ       = r_occ;
        n_cyl       = r_cyl;
        n_hd        = r_hd;
        n_out_valid = r_out_valid;
        n_slot      = r_slot;
        n_id_cyl    = r_id_cyl;
        n_id_hd     = r_id_hd;
        n_id_sec    = r_id_sec;
        n_code      = r_code;
        n_err       = r_err;
        n_last      = r_last;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cyl = i_cylinder;
                    n_hd  = i_head;
                    n_pos = '0;
                    n_sec = SEC_W'(1);
                    n_k   = '0;
                    n_occ = '0;
                    if (bad_il) begin
                        // single error word, all fields zero but error and last
                        n_out_valid = 1'b1;
                        n_slot      = '0;
                        n_id_cyl    = '0;
                        n_id_hd     = '0;
                        n_id_sec    = '0;
                        n_code      = '0;
                        n_err       = 1'b1;
                        n_last      = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                // table write happens this cycle
                n_occ[r_pos] = 1'b1;
                if (r_sec == n_eff) begin
                    n_state = ST_RD;
                end else begin
                    n_sec = r_sec + SEC_W'(1);
                    n_pos = step_rsp.next;
                    if (step_rsp.wrap) begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // a free slot always exists: fewer than N are filled here
                if (!r_occ[r_pos]) begin
                    n_state = ST_PLACE;
                end else begin
                    n_pos = step_rsp.next;
                end
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                n_out_valid = 1'b1;
                n_slot      = r_k;
                n_id_cyl    = r_cyl;
                n_id_hd     = r_hd;
                n_id_sec    = r_occ[r_k] ? ram_rd_data : '0;
                n_code      = code;
                n_err       = 1'b0;
                n_last      = k_last;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + SLOT_W'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_spt       <= RST_SECTORS_PER_TRACK;
            r_il        <= RST_INTERLEAVE;
            r_size      <= RST_SECTOR_SIZE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SECTORS_PER_TRACK: r_spt  <= i_cfg_wr_data[SEC_W-1:0];
                    REG_INTERLEAVE:        r_il   <= i_cfg_wr_data[SEC_W-1:0];
                    REG_SECTOR_SIZE:       r_size <= i_cfg_wr_data;
                    default: ;
                endcase
            end
        end
        r_pos    <= n_pos;
        r_sec    <= n_sec;
        r_k      <= n_k;
        r_occ    <= n_occ;
        r_cyl    <= n_cyl;
        r_hd     <= n_hd;
        r_slot   <= n_slot;
        r_id_cyl <= n_id_cyl;
        r_id_hd  <= n_id_hd;
        r_id_sec <= n_id_sec;
        r_code   <= n_code;
        r_err    <= n_err;
        r_last   <= n_last;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_slot;
    assign o_id_cylinder = r_id_cyl;
    assign o_id_head     = r_id_hd;
    assign o_id_sector   = r_id_sec;
    assign o_size_code   = r_code;
    assign o_error       = r_err;
    assign o_last        = r_last;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sector interleave ID generator
// Track requests are queued by the stimulus process and offered by a clocked
// driver; each accepted request is expanded by a local slot-table model into
// the ID words it should produce. A clocked monitor takes the block's words
// under random back-pressure and checks them field by field, in order.
// Registers are reprogrammed only with the block drained.
// ----------------------------------------------------------------------------
module tb_top;
    import sig_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index
    localparam int SETTLE_CYCLES = 6;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int STAGE_ITEMS   = 100;

    typedef struct packed {
        logic [7:0] cyl;
        logic [7:0] head;
    } t_track_req;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [7:0]        cyl;
        logic [7:0]        head;
        logic [SEC_W-1:0]  sector;
        logic [7:0]        code;
        logic              error;
        logic              last;
    } t_id_word;

    // DUT connections; the inputs are all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            cylinder      = '0;
    logic [7:0]            head          = '0;
    logic                  o_out_valid;
    logic                  out_stall     = 1'b0;
    logic [SLOT_W-1:0]     o_slot;
    logic [7:0]            o_id_cylinder;
    logic [7:0]            o_id_head;
    logic [SEC_W-1:0]      o_id_sector;
    logic [7:0]            o_size_code;
    logic                  o_error;
    logic                  o_last;

    // Local copy of the format registers
    logic [SEC_W-1:0] fmt_spt  = RST_SECTORS_PER_TRACK;
    logic [SEC_W-1:0] fmt_il   = RST_INTERLEAVE;
    logic [15:0]      fmt_size = RST_SECTOR_SIZE;

    t_track_req track_pending[$];
    t_id_word   ids_expected[$];
    int         id_errors   = 0;
    int         tx_idle_pct = 28;
    int         rx_idle_pct = 65;
    bit         hold_arm    = 1'b0;
    bit         hold_taken  = 1'b0;
    int         hold_left   = 0;

    sector_interleave_id_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_cylinder    (cylinder),
        .i_head        (head),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_slot        (o_slot),
        .o_id_cylinder (o_id_cylinder),
        .o_id_head     (o_id_head),
        .o_id_sector   (o_id_sector),
        .o_size_code   (o_size_code),
        .o_error       (o_error),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expand one track request into its ID words with the current format
    task automatic predict_track_ids(input logic [7:0] cyl, input logic [7:0] hd);
        int       n;
        int       il;
        int       pos;
        int       k;
        int       slot_map[32];
        logic [7:0] code;
        t_id_word w;
        n  = int'(fmt_spt);
        il = int'(fmt_il);
        if (n > MAX_SECTORS) n = MAX_SECTORS;
        if (n > 32) n = 32;
        if (il == 0) il = 1;
        // bad interleave: a single error word, all fields zero but error and last
        if (il >= n) begin
            w = '{slot: '0, cyl: '0, head: '0, sector: '0, code: '0, error: 1'b1,
                  last: 1'b1};
            ids_expected.push_back(w);
            return;
        end
        code = fmt_size[15:8];
        if (code == CODE_REMAP_FROM) code = CODE_REMAP_TO;
        foreach (slot_map[i]) slot_map[i] = 0;
        pos = 0;
        for (int sec = 1; sec <= n; sec++) begin
            slot_map[pos] = sec;
            if (sec == n) break;
            pos += il;
            // wrapped: walk forward to the next free slot
            if (pos >= n) begin
                pos -= n;
                for (k = 0; k < n && slot_map[pos] != 0; k++) begin
                    pos++;
                    if (pos >= n) pos = 0;
                end
            end
        end
        for (k = 0; k < n; k++) begin
            w.slot   = k[SLOT_W-1:0];
            w.cyl    = cyl;
            w.head   = hd;
            w.sector = slot_map[k][SEC_W-1:0];
            w.code   = code;
            w.error  = 1'b0;
            w.last   = (k + 1 == n);
            ids_expected.push_back(w);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            id_errors++;
        end
    endtask

    // Request driver: offer the next queued track once the last one is taken
    always @(posedge i_clk) begin
        t_track_req req;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) predict_track_ids(cylinder, head);
            if (!in_valid || !o_in_stall) begin
                if (track_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    req = track_pending.pop_front();
                    in_valid <= 1'b1;
                    cylinder <= req.cyl;
                    head     <= req.head;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls, plus one long hold when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Word monitor: check each taken word against the oldest expectation
    always @(posedge i_clk) begin
        t_id_word w;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (ids_expected.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual slot %0d sector %0d",
                         $time, o_slot, o_id_sector);
                id_errors++;
            end else begin
                w = ids_expected.pop_front();
                compare_field("slot", 8'(w.slot), 8'(o_slot));
                compare_field("id_cylinder", w.cyl, o_id_cylinder);
                compare_field("id_head", w.head, o_id_head);
                compare_field("id_sector", 8'(w.sector), 8'(o_id_sector));
                compare_field("size_code", w.code, o_size_code);
                compare_field("error", 8'(w.error), 8'(o_error));
                compare_field("last", 8'(w.last), 8'(o_last));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_SECTORS_PER_TRACK: fmt_spt  = data[SEC_W-1:0];
            REG_INTERLEAVE:        fmt_il   = data[SEC_W-1:0];
            REG_SECTOR_SIZE:       fmt_size = data;
            default: ;
        endcase
    endtask

    // Program the whole format; upper data bits are random noise on the
    // narrow registers
    task automatic program_format(input logic [SEC_W-1:0] n, input logic [SEC_W-1:0] il,
                                  input logic [15:0] size, input bit with_spare);
        if (with_spare) write_reg(REG_SPARE, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_SECTORS_PER_TRACK, {10'($urandom_range(0, 1023)), n});
        write_reg(REG_INTERLEAVE, {10'($urandom_range(0, 1023)), il});
        write_reg(REG_SECTOR_SIZE, size);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until no track is queued, offered or owed any word
    task automatic wait_drained();
        do @(negedge i_clk);
        while (track_pending.size() != 0 || in_valid || ids_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_track(input logic [7:0] cyl, input logic [7:0] hd);
        t_track_req req;
        req.cyl  = cyl;
        req.head = hd;
        track_pending.push_back(req);
    endtask

    task automatic directed_track(input logic [SEC_W-1:0] n, input logic [SEC_W-1:0] il,
                                  input logic [15:0] size, input logic [7:0] cyl,
                                  input logic [7:0] hd);
        program_format(n, il, size, 1'b0);
        push_track(cyl, hd);
        wait_drained();
    endtask

    // Stimulus
    initial begin
        int          stage;
        int          stage_items;
        int          batch;
        int          pick;
        int          n_eff;
        logic [5:0]  n;
        logic [5:0]  il;
        logic [15:0] size;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset format, extremes of the request fields
        push_track(8'h00, 8'h00);
        push_track(8'hFF, 8'hFF);
        wait_drained();

        // directed formats
        program_format(6'd32, 6'd1, 16'h0200, 1'b1);
        push_track(8'hAA, 8'h55);
        wait_drained();
        directed_track(6'd32, 6'd31, 16'hFFFF, 8'h55, 8'hAA);   // interleave N-1
        directed_track(6'd32, 6'd32, 16'h0200, 8'h01, 8'h80);   // interleave equals N
        directed_track(6'd63, 6'd5,  16'h0400, 8'h80, 8'h01);   // N clamped, code 4 -> 3
        directed_track(6'd40, 6'd32, 16'h0200, 8'h12, 8'h34);   // clamped N, bad step
        directed_track(6'd0,  6'd0,  16'h0200, 8'h7F, 8'hFE);   // no sectors
        directed_track(6'd1,  6'd0,  16'h0100, 8'hFE, 8'h7F);   // single sector
        directed_track(6'd2,  6'd0,  16'h0000, 8'h0F, 8'hF0);   // zero step as one
        directed_track(6'd2,  6'd1,  16'h04FF, 8'hF0, 8'h0F);
        directed_track(6'd3,  6'd2,  16'h0300, 8'h33, 8'hCC);
        directed_track(6'd18, 6'd2,  16'h0200, 8'h4F, 8'h01);
        directed_track(6'd18, 6'd17, 16'h0200, 8'h50, 8'h00);
        directed_track(6'd18, 6'd63, 16'h0200, 8'h51, 8'h01);   // step far past N
        directed_track(6'd12, 6'd4,  16'h0500, 8'h02, 8'h00);   // heavy collisions
        directed_track(6'd16, 6'd8,  16'h8000, 8'h03, 8'h01);
        directed_track(6'd9,  6'd3,  16'h00FF, 8'h04, 8'h00);
        directed_track(6'd32, 6'd16, 16'h0180, 8'h05, 8'h01);
        directed_track(6'd5,  6'd4,  16'h0401, 8'h06, 8'h00);
        directed_track(6'd33, 6'd7,  16'h1000, 8'hC3, 8'h3C);

        // random formats in three idling regimes
        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin tx_idle_pct = 28; rx_idle_pct = 65; end
                1: begin tx_idle_pct = 65; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            stage_items = 0;
            while (stage_items < STAGE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      n = 6'($urandom_range(33, 63));
                else if (pick < 20) n = 6'($urandom_range(1, 4));
                else                n = 6'($urandom_range(1, 32));
                n_eff = (n > 32) ? 32 : int'(n);
                pick = $urandom_range(0, 99);
                if (pick < 12)      il = 6'($urandom_range(0, 63));
                else if (pick < 20) il = '0;
                else                il = 6'($urandom_range(1, (n_eff > 1) ? n_eff - 1 : 1));
                if ($urandom_range(0, 4) == 0) size = {8'd4, 8'($urandom_range(0, 255))};
                else                           size = 16'($urandom_range(0, 16'hFFFF));
                program_format(n, il, size, $urandom_range(0, 7) == 0);

                batch = $urandom_range(4, 12);
                for (int i = 0; i < batch; i++) begin
                    // sender pauses mid-batch until the block has drained
                    if (batch >= 8 && i == batch / 2) wait_drained();
                    push_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    if (stage == 2 && i == 2 && !hold_arm) hold_arm = 1'b1;
                end
                stage_items += batch;
                wait_drained();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (id_errors == 0)
            $display("sector_interleave_id_generator regression: pass");
        else
            $display("sector_interleave_id_generator regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("sector_interleave_id_generator regression: fail");
        $finish;
    end

endmodule
